// ----- rtl/qte_pkg.sv -----
`timescale 1ns / 1ps
package qte_pkg;

  // component width, Q1.(CB-1)
  localparam int CB = 16;
  localparam int PW = 2 * CB;
  localparam int Q30W = 33;
  // CORDIC vector and angle widths
  localparam int SW = 36;
  localparam int AW = 34;
  localparam int STEPS = 30;
  localparam int SQ_STEPS = 31;
  localparam int RW = 31;
  localparam int RMW = 34;
  localparam int NW = 62;
  localparam int CORDIC_LAT = STEPS + 1;
  localparam logic signed [SW-1:0] ONE_Q30 = SW'(64'sd1 << 30);
  localparam logic signed [15:0] HALF_PI = 16'sd16384;

  typedef struct packed {
    logic signed [SW-1:0] sinr;
    logic signed [SW-1:0] cosr;
    logic signed [SW-1:0] siny;
    logic signed [SW-1:0] cosy;
    logic signed [SW-1:0] sinp;
    logic sat_pos;
    logic sat_neg;
  } item_t;

  // product brought to Q.30, floor rounding
  function automatic logic signed [Q30W-1:0] q30(input logic signed [PW-1:0] p);
    logic signed [PW+32:0] e;
    e = (PW+33)'(p);
    if (CB >= 16) e = e >>> (PW - 32);
    else e = e <<< (32 - PW);
    return e[Q30W-1:0];
  endfunction

  // arctangent of 2^-i, 2^32 units per turn
  function automatic logic signed [AW-1:0] atan_c(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h20000000;   1: v = 32'h12E4051E;   2: v = 32'h09FB385B;
      3: v = 32'h051111D4;   4: v = 32'h028B0D43;   5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;   7: v = 32'h00517C55;   8: v = 32'h0028BE53;
      9: v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D; 16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30; 19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146; 22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029; 25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005; 28: v = 32'h00000003;  29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

endpackage

// ----- rtl/qte_front.sv -----
`timescale 1ns / 1ps
module qte_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [qte_pkg::CB-1:0] quat_x,
  input  logic signed [qte_pkg::CB-1:0] quat_y,
  input  logic signed [qte_pkg::CB-1:0] quat_z,
  input  logic signed [qte_pkg::CB-1:0] quat_w,
  output logic out_valid,
  output qte_pkg::item_t out_item
);
  import qte_pkg::*;

  logic v1;
  logic signed [Q30W-1:0] wx, yz, xx, yy, wz, xy, zz, wy, zx;
  logic signed [SW-1:0] sinp;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      out_valid <= v1;
    end
    wx <= q30(PW'(quat_w * quat_x));
    yz <= q30(PW'(quat_y * quat_z));
    xx <= q30(PW'(quat_x * quat_x));
    yy <= q30(PW'(quat_y * quat_y));
    wz <= q30(PW'(quat_w * quat_z));
    xy <= q30(PW'(quat_x * quat_y));
    zz <= q30(PW'(quat_z * quat_z));
    wy <= q30(PW'(quat_w * quat_y));
    zx <= q30(PW'(quat_z * quat_x));
    out_item.sinr <= (SW'(wx) + SW'(yz)) <<< 1;
    out_item.cosr <= ONE_Q30 - ((SW'(xx) + SW'(yy)) <<< 1);
    out_item.siny <= (SW'(wz) + SW'(xy)) <<< 1;
    out_item.cosy <= ONE_Q30 - ((SW'(yy) + SW'(zz)) <<< 1);
    out_item.sinp <= sinp;
    out_item.sat_pos <= (sinp >= ONE_Q30);
    out_item.sat_neg <= (sinp <= -ONE_Q30);
  end

  assign sinp = (SW'(wy) - SW'(zx)) <<< 1;

endmodule

// ----- rtl/qte_queue.sv -----
`timescale 1ns / 1ps
module qte_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  qte_pkg::item_t push_item,
  output logic full,
  output logic pop_valid,
  output qte_pkg::item_t pop_item
);
  import qte_pkg::*;

  item_t mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic pop;

  assign pop = (count != 2'd0);
  assign full = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
      pop_valid <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
      pop_valid <= pop;
    end
    if (push) mem[wr_ptr] <= push_item;
    if (pop) pop_item <= mem[rd_ptr];
  end

endmodule

// ----- rtl/qte_cordic.sv -----
`timescale 1ns / 1ps
module qte_cordic (
  input  logic clk,
  input  logic signed [qte_pkg::SW-1:0] vec_y,
  input  logic signed [qte_pkg::SW-1:0] vec_x,
  output logic signed [15:0] angle
);
  import qte_pkg::*;

  logic signed [SW-1:0] xs [STEPS+1];
  logic signed [SW-1:0] ys [STEPS+1];
  logic signed [AW-1:0] as [STEPS+1];
  logic zs [STEPS+1];
  logic signed [AW-1:0] rnd;

  // quadrant fold for x < 0
  always_ff @(posedge clk) begin
    zs[0] <= (vec_x == '0) && (vec_y == '0);
    if (vec_x < 0) begin
      if (vec_y >= 0) begin
        xs[0] <= vec_y;
        ys[0] <= -vec_x;
        as[0] <= AW'(ONE_Q30);
      end else begin
        xs[0] <= -vec_y;
        ys[0] <= vec_x;
        as[0] <= -AW'(ONE_Q30);
      end
    end else begin
      xs[0] <= vec_x;
      ys[0] <= vec_y;
      as[0] <= '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      zs[i+1] <= zs[i];
      if (ys[i] > 0) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        as[i+1] <= as[i] + atan_c(i);
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        as[i+1] <= as[i] - atan_c(i);
      end
    end
  end

  assign rnd = as[STEPS] + AW'(32768);
  assign angle = zs[STEPS] ? 16'sd0 : rnd[31:16];

endmodule

// ----- rtl/qte_back.sv -----
`timescale 1ns / 1ps
module qte_back (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  qte_pkg::item_t in_item,
  output logic out_valid,
  output logic signed [15:0] roll_angle,
  output logic signed [15:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic pitch_saturated
);
  import qte_pkg::*;

  typedef struct packed {
    item_t it;
    logic [NW-1:0] n;
    logic [RMW-1:0] rem;
    logic [RW-1:0] root;
  } sq_t;

  logic v1, v2;
  item_t it1;
  logic [59:0] s2;
  logic [29:0] mag;
  sq_t sq [SQ_STEPS+1];
  logic sv [SQ_STEPS+1];
  logic dv [CORDIC_LAT+1];
  logic dpos [CORDIC_LAT+1];
  logic dneg [CORDIC_LAT+1];
  logic signed [15:0] r_ang, p_ang, y_ang;

  // only used when |sinp| < 1, so 30 bits hold its magnitude
  assign mag = in_item.sinp[SW-1] ? 30'(-in_item.sinp) : in_item.sinp[29:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
    it1 <= in_item;
    s2 <= mag * mag;
    sq[0].it <= it1;
    sq[0].n <= NW'((61'd1 << 60) - 61'(s2));
    sq[0].rem <= '0;
    sq[0].root <= '0;
  end
  assign sv[0] = v2;

  // restoring square root, one result bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [RMW+1:0] t, trial;
    assign t = {sq[k].rem, sq[k].n[NW-1-2*k -: 2]};
    assign trial = (RMW+2)'({sq[k].root, 2'b01});
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else sv[k+1] <= sv[k];
      sq[k+1].it <= sq[k].it;
      sq[k+1].n <= sq[k].n;
      if (t >= trial) begin
        sq[k+1].rem <= RMW'(t - trial);
        sq[k+1].root <= {sq[k].root[RW-2:0], 1'b1};
      end else begin
        sq[k+1].rem <= RMW'(t);
        sq[k+1].root <= {sq[k].root[RW-2:0], 1'b0};
      end
    end
  end

  qte_cordic u_roll (.clk, .vec_y(sq[SQ_STEPS].it.sinr),
                     .vec_x(sq[SQ_STEPS].it.cosr), .angle(r_ang));
  qte_cordic u_pitch (.clk, .vec_y(sq[SQ_STEPS].it.sinp),
                      .vec_x(SW'(sq[SQ_STEPS].root)), .angle(p_ang));
  qte_cordic u_yaw (.clk, .vec_y(sq[SQ_STEPS].it.siny),
                    .vec_x(sq[SQ_STEPS].it.cosy), .angle(y_ang));

  assign dv[0] = sv[SQ_STEPS];
  assign dpos[0] = sq[SQ_STEPS].it.sat_pos;
  assign dneg[0] = sq[SQ_STEPS].it.sat_neg;

  for (genvar j = 0; j < CORDIC_LAT; j++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else dv[j+1] <= dv[j];
      dpos[j+1] <= dpos[j];
      dneg[j+1] <= dneg[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= dv[CORDIC_LAT];
    roll_angle <= r_ang;
    yaw_angle <= y_ang;
    if (dpos[CORDIC_LAT]) pitch_angle <= HALF_PI;
    else if (dneg[CORDIC_LAT]) pitch_angle <= -HALF_PI;
    else pitch_angle <= p_ang;
    pitch_saturated <= dpos[CORDIC_LAT] | dneg[CORDIC_LAT];
  end

endmodule

// ----- rtl/quaternion_to_euler_angles.sv -----
`timescale 1ns / 1ps
// Quaternion to ZYX roll, pitch and yaw. Pulse start with a Q1.15 quaternion
// whenever busy is low; busy stays low in practice, so one beat can enter
// every clock. Each beat yields exactly one result, shown for one cycle
// with done high; the receiver cannot stall it and must take it then. The
// path runs through the 31-stage square root for the pitch cosine
// followed by the 31-stage CORDIC vectoring units. Angles are binary
// angles (32768 = pi, +pi wraps to -32768). A pitch sine of magnitude one
// or more clamps pitch to +/-16384 and sets pitch_saturated. The quaternion
// is not normalized and no state is kept between beats.
module quaternion_to_euler_angles (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [qte_pkg::CB-1:0] quat_x,
  input  logic signed [qte_pkg::CB-1:0] quat_y,
  input  logic signed [qte_pkg::CB-1:0] quat_z,
  input  logic signed [qte_pkg::CB-1:0] quat_w,
  output logic done,
  output logic signed [15:0] roll_angle,
  output logic signed [15:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic pitch_saturated
);
  import qte_pkg::*;

  logic f_valid, q_valid;
  item_t f_item, q_item;
  logic accept;

  assign accept = start & ~busy;

  // front: products and sums, clamp classification of the pitch sine
  qte_front u_front (
    .clk, .rst, .in_valid(accept), .quat_x, .quat_y, .quat_z, .quat_w,
    .out_valid(f_valid), .out_item(f_item)
  );

  // two-beat queue; back drains one per cycle so it never fills
  qte_queue u_queue (
    .clk, .rst, .push(f_valid), .push_item(f_item), .full(busy),
    .pop_valid(q_valid), .pop_item(q_item)
  );

  // back: square root and three CORDIC pipelines
  qte_back u_back (
    .clk, .rst, .in_valid(q_valid), .in_item(q_item), .out_valid(done),
    .roll_angle, .pitch_angle, .yaw_angle, .pitch_saturated
  );

endmodule

// ----- rtl/qte_checker.sv -----
`timescale 1ns / 1ps
module qte_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done,
  input logic signed [15:0] pitch_angle,
  input logic pitch_saturated
);

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_sat_pitch: assert property (@(posedge clk) disable iff (rst)
    done && pitch_saturated |-> pitch_angle == 16'sd16384 || pitch_angle == -16'sd16384)
    else $error("saturated pitch not at half pi");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    done |-> pitch_angle <= 16'sd16384 && pitch_angle >= -16'sd16384)
    else $error("pitch out of range");

  a_rst_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result after reset");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
  .clk, .rst, .busy, .done, .pitch_angle, .pitch_saturated
);

// ----- sim/tb_quaternion_to_euler_angles.sv -----
`timescale 1ns / 1ps
module tb_quaternion_to_euler_angles;
  import qte_pkg::*;

  localparam int N_RANDOM = 530;
  localparam int LATENCY = 69;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               sat;
  } euler_t;

  // directed row: quaternion, and a typed-in answer where it is obvious
  typedef struct {
    logic signed [CB-1:0] x, y, z, w;
    bit                   known;
    euler_t               ans;
  } quat_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [CB-1:0] quat_x, quat_y, quat_z, quat_w;
  logic done;
  logic signed [15:0] roll_angle, pitch_angle, yaw_angle;
  logic pitch_saturated;

  euler_t angles_pending[$];
  int     mismatches;
  int     quiet_cycles;

  quaternion_to_euler_angles i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
    .yaw_angle(yaw_angle), .pitch_saturated(pitch_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------- predictor ----------------
  localparam longint Q30_ONE = 64'sd1 << 30;

  function automatic longint floor_sr(longint v, int s);
    return v >>> s;
  endfunction

  // product of two components in Q.30, floor rounding
  function automatic longint prod_q30(longint a, longint b);
    longint p;
    p = a * b;
    if (CB >= 16) return floor_sr(p, 2 * CB - 32);
    return p <<< (32 - 2 * CB);
  endfunction

  function automatic longint arctan_step(int i);
    longint tab[30] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
    return tab[i];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // CORDIC vectoring atan2, binary-angle result
  function automatic logic signed [15:0] vector_angle(longint y, longint x);
    longint ang, t, dx, dy;
    logic [63:0] u;
    ang = 0;
    if (x == 0 && y == 0) return 16'sd0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; ang = Q30_ONE;
      end else begin
        x = -y; y = t; ang = -Q30_ONE;
      end
    end
    for (int i = 0; i < 30; i++) begin
      dx = floor_sr(y, i);
      dy = floor_sr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; ang += arctan_step(i);
      end else begin
        x -= dx; y += dy; ang -= arctan_step(i);
      end
    end
    u = ang + 64'h8000;
    return u[31:16];
  endfunction

  function automatic euler_t quat_to_euler(logic signed [CB-1:0] qx, qy, qz, qw);
    longint x, y, z, w, sinr, cosr, siny, cosy, sinp;
    logic [63:0] c;
    euler_t e;
    x = qx; y = qy; z = qz; w = qw;
    sinr = 2 * (prod_q30(w, x) + prod_q30(y, z));
    cosr = Q30_ONE - 2 * (prod_q30(x, x) + prod_q30(y, y));
    siny = 2 * (prod_q30(w, z) + prod_q30(x, y));
    cosy = Q30_ONE - 2 * (prod_q30(y, y) + prod_q30(z, z));
    sinp = 2 * (prod_q30(w, y) - prod_q30(z, x));
    e.sat = 1'b0;
    if (sinp >= Q30_ONE) begin
      e.pitch = HALF_PI; e.sat = 1'b1;
    end else if (sinp <= -Q30_ONE) begin
      e.pitch = -HALF_PI; e.sat = 1'b1;
    end else begin
      c = int_sqrt((64'd1 << 60) - 64'(sinp * sinp));
      e.pitch = vector_angle(sinp, longint'(c));
    end
    e.roll = vector_angle(sinr, cosr);
    e.yaw = vector_angle(siny, cosy);
    return e;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // results are valid for exactly one cycle, so sample every rising edge
  always @(posedge clk) begin
    euler_t want;
    if (!rst && done) begin
      if (angles_pending.size() == 0) begin
        report_mismatch("unexpected result", longint'(1), longint'(0));
      end else begin
        want = angles_pending.pop_front();
        if (roll_angle !== want.roll)
          report_mismatch("roll", longint'(roll_angle), longint'(want.roll));
        if (pitch_angle !== want.pitch)
          report_mismatch("pitch", longint'(pitch_angle), longint'(want.pitch));
        if (yaw_angle !== want.yaw)
          report_mismatch("yaw", longint'(yaw_angle), longint'(want.yaw));
        if (pitch_saturated !== want.sat)
          report_mismatch("pitch_saturated", longint'(pitch_saturated),
                          longint'(want.sat));
      end
    end
  end

  // watchdog: cycles in which no beat moves on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  // drive one beat, return once it has been taken; start stays high between
  // back-to-back beats and is dropped only by the caller on an idle cycle
  task automatic send_quat(logic signed [CB-1:0] x, y, z, w, bit known, euler_t ans);
    euler_t e;
    quat_x <= x; quat_y <= y; quat_z <= z; quat_w <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    e = quat_to_euler(x, y, z, w);
    // typed answers cross-check the predictor too
    if (known && e !== ans) report_mismatch("directed table", longint'(e), longint'(ans));
    angles_pending.push_back(known ? ans : e);
    @(negedge clk);
  endtask

  // idle runs follow 13 percent of beats and keep about a quarter of cycles idle
  task automatic maybe_idle(bit allow);
    if (allow && $urandom_range(99) < 13) begin
      start <= 1'b0;
      quat_x <= CB'($urandom); quat_y <= CB'($urandom);
      quat_z <= CB'($urandom); quat_w <= CB'($urandom);
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  function automatic logic signed [CB-1:0] rand_comp(int mode);
    case (mode)
      0: return CB'($urandom);
      1: return CB'($urandom_range(32767));
      2: return $signed(CB'($urandom_range(0, 65535))) >>> $urandom_range(0, 8);
      default: return ($urandom_range(1)) ? 16'sh7FFF : -16'sh8000;
    endcase
  endfunction

  quat_row_t dir_rows[$];

  function automatic quat_row_t mk(int x, y, z, w, bit known = 0,
                                   int r = 0, int p = 0, int yw = 0, bit s = 0);
    quat_row_t q;
    q.x = CB'(x); q.y = CB'(y); q.z = CB'(z); q.w = CB'(w); q.known = known;
    q.ans = '{roll: 16'(r), pitch: 16'(p), yaw: 16'(yw), sat: s};
    return q;
  endfunction

  initial begin
    real n, a, b, c, d;
    rst = 1'b1;
    start = 1'b0;
    quat_x = '0; quat_y = '0; quat_z = '0; quat_w = '0;
    mismatches = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // identity and all-zero give zero angles; exact clamps at pitch sine +/-1,
    // where roll and yaw land on pi and wrap to -32768
    dir_rows.push_back(mk(0, 0, 0, 32767, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 0, 0, -32768, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk(0, 23170, 0, 23170));
    dir_rows.push_back(mk(0, -23170, 0, 23170));
    dir_rows.push_back(mk(0, 32767, 0, 32767, 1, -32768, 16384, -32768, 1));
    dir_rows.push_back(mk(0, -32768, 0, 32767, 1, -32768, -16384, -32768, 1));
    dir_rows.push_back(mk(32767, 0, 0, 0));
    dir_rows.push_back(mk(-32768, 0, 0, 0));
    dir_rows.push_back(mk(0, 32767, 0, 0));
    dir_rows.push_back(mk(0, 0, 32767, 0));
    dir_rows.push_back(mk(0, 0, -32768, 0));
    dir_rows.push_back(mk(23170, 0, 0, 23170));
    dir_rows.push_back(mk(0, 0, 23170, 23170));
    dir_rows.push_back(mk(-32768, -32768, -32768, -32768));
    dir_rows.push_back(mk(32767, 32767, 32767, 32767));
    dir_rows.push_back(mk(16384, 16384, 16384, 16384));
    dir_rows.push_back(mk(-32768, 32767, -32768, 32767));
    dir_rows.push_back(mk(1, -1, 1, -1));
    dir_rows.push_back(mk(-1, -1, -1, -1));
    dir_rows.push_back(mk(0, 16384, -16384, 0));
    foreach (dir_rows[i]) begin
      send_quat(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].w,
                dir_rows[i].known, dir_rows[i].ans);
      maybe_idle(1);
    end

    // drain completely before going on
    start <= 1'b0;
    while (angles_pending.size() != 0) @(negedge clk);

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 4 != 0) begin
        // mostly near-unit quaternions so all angle ranges are covered
        a = $urandom_range(0, 65535) - 32768.0; b = $urandom_range(0, 65535) - 32768.0;
        c = $urandom_range(0, 65535) - 32768.0; d = $urandom_range(0, 65535) - 32768.0;
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        send_quat(CB'($rtoi(a / n * 32767.0)), CB'($rtoi(b / n * 32767.0)),
                  CB'($rtoi(c / n * 32767.0)), CB'($rtoi(d / n * 32767.0)), 0, '0);
      end else begin
        send_quat(rand_comp($urandom_range(3)), rand_comp($urandom_range(3)),
                  rand_comp($urandom_range(3)), rand_comp($urandom_range(3)), 0, '0);
      end
      // a long run in the middle with no gaps at all
      maybe_idle(k < 200 || k > 330);
    end
    start <= 1'b0;

    while (angles_pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
